// ===== rtl/tbcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcbp_pkg
// Shared types, constants and counter helpers for the two-bit counter
// branch predictor.
// ----------------------------------------------------------------------------
package tbcbp_pkg;

    // Field widths fixed by the branch interface
    localparam int ADDR_W   = 64;
    localparam int HIST_W   = 64;
    localparam int CFG_W    = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Address chunks folded into the index on non power-of-two tables
    localparam int FOLD_W   = 8;
    localparam int FOLDS    = ADDR_W / FOLD_W;

    // Register map (word index taken from paddr[2])
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_HISTORY_BITS = 1'b0;

    // Two-bit saturating counter
    typedef logic [1:0] t_ctr;
    localparam t_ctr CTR_RESET = 2'd1;
    localparam t_ctr CTR_MAX   = 2'd3;
    localparam t_ctr CTR_MIN   = 2'd0;

    // Table status seen by the top level
    typedef struct packed {
        logic clearing;
        logic writeback;
    } t_tbl_status;

    // Step the counter one toward the outcome, saturating at both ends
    function automatic t_ctr ctr_next(input t_ctr ctr, input logic tk);
        t_ctr res;
        res = ctr;
        if (tk) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

    // Prediction is the counter's upper bit; a miss is a disagreement
    function automatic logic ctr_miss(input t_ctr ctr, input logic tk);
        return ctr[1] ^ tk;
    endfunction

endpackage

// ===== rtl/tbcbp_index.sv =====
// ----------------------------------------------------------------------------
// tbcbp_index
// Global history register and table index generation: folds history into
// the branch address and reduces the result modulo the table size.
// ----------------------------------------------------------------------------
module tbcbp_index #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_go,
    input  logic [tbcbp_pkg::ADDR_W-1:0]         i_branch_address,
    input  logic                                 i_taken,
    input  logic [tbcbp_pkg::CFG_W-1:0]          i_history_bits,
    output logic                                 o_done,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     o_index
);
    import tbcbp_pkg::*;

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam logic [CFG_W-1:0] HB_MAX = CFG_W'(HIST_W);

    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [CFG_W-1:0]  hb;
    logic [CFG_W-1:0]  sh_full;
    logic [5:0]        sh;
    logic [ADDR_W-1:0] hash;

    // Weight of each address chunk: 2^(FOLD_W*k) mod TABLE_ENTRIES
    function automatic logic [FOLDS*IDXW-1:0] fold_weights();
        logic [FOLDS*IDXW-1:0] res;
        longint unsigned       w;
        res = '0;
        w   = 64'd1;
        for (int k = 0; k < FOLDS; k++) begin
            res[IDXW*k +: IDXW] = IDXW'(w % TABLE_ENTRIES);
            w = (w << FOLD_W) % TABLE_ENTRIES;
        end
        return res;
    endfunction

    // Saturate history length, shift in outcome, fold into address
    always_comb begin
        hb      = (i_history_bits > HB_MAX) ? HB_MAX : i_history_bits;
        sh_full = HB_MAX - hb;
        sh      = sh_full[5:0];
        if (hb == '0) begin
            n_hist = '0;
            hash   = i_branch_address;
        end else begin
            n_hist = {r_hist[HIST_W-2:0], i_taken};
            hash   = i_branch_address ^ (n_hist << sh);
        end
    end

    // Hold global history, advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_go) begin
            r_hist <= n_hist;
        end
    end

    generate
        if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
            logic            r_done;
            logic [IDXW-1:0] r_index;

            // Mask low bits for a power-of-two table
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_go;
                end
                if (i_go) r_index <= hash[IDXW-1:0];
            end

            assign o_done  = r_done;
            assign o_index = r_index;
        end else begin : g_mod
            localparam int SUM_W = 27;
            localparam logic [IDXW:0]         N_C     = (IDXW+1)'(TABLE_ENTRIES);
            localparam logic [SUM_W-1:0]      RECIP   = SUM_W'((64'd1 << SUM_W) / TABLE_ENTRIES);
            localparam logic [FOLDS*IDXW-1:0] WEIGHTS = fold_weights();

            logic                  r_v1;
            logic                  r_v2;
            logic                  r_v3;
            logic                  r_done;
            logic [ADDR_W-1:0]     r_word;
            logic [SUM_W-1:0]      r_sum;
            logic [SUM_W-1:0]      r_quo;
            logic [IDXW-1:0]       r_rem;
            logic [SUM_W-1:0]      sum;
            logic [2*SUM_W-1:0]    quo_prod;
            logic [2*IDXW+1:0]     qn_prod;
            logic [IDXW:0]         diff;

            // Fold chunks by weight, estimate quotient by reciprocal, take remainder
            always_comb begin
                sum = '0;
                for (int k = 0; k < FOLDS; k++) begin
                    sum = sum + SUM_W'(r_word[FOLD_W*k +: FOLD_W])
                              * SUM_W'(WEIGHTS[IDXW*k +: IDXW]);
                end
                quo_prod = {{SUM_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, RECIP};
                qn_prod  = {{(IDXW+1){1'b0}}, r_quo[IDXW:0]} * {{(IDXW+1){1'b0}}, N_C};
                diff     = r_sum[IDXW:0] - qn_prod[IDXW:0];
            end

            // Three stages: fold, quotient estimate, remainder with one correction
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v1   <= 1'b0;
                    r_v2   <= 1'b0;
                    r_v3   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v1   <= i_go;
                    r_v2   <= r_v1;
                    r_v3   <= r_v2;
                    r_done <= r_v3;
                end
                if (i_go) r_word <= hash;
                if (r_v1) r_sum <= sum;
                if (r_v2) r_quo <= quo_prod[2*SUM_W-1:SUM_W];
                if (r_v3) begin
                    r_rem <= (diff >= N_C) ? (diff[IDXW-1:0] - N_C[IDXW-1:0])
                                           : diff[IDXW-1:0];
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem;
        end
    endgenerate

endmodule

// ===== rtl/tbcbp_table.sv =====
// ----------------------------------------------------------------------------
// tbcbp_table
// Counter table memory with read-modify-write update and a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module tbcbp_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_lookup,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_index,
    input  logic                              i_taken,
    output tbcbp_pkg::t_tbl_status            o_status,
    output logic                              o_valid,
    output logic                              o_mispredicted
);
    import tbcbp_pkg::*;

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam logic [IDXW-1:0] LAST_ADDR = IDXW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    t_state          r_state;
    logic [IDXW-1:0] r_clr_addr;
    logic [IDXW-1:0] r_idx;
    logic            r_tk;
    logic            r_valid;
    logic            r_miss;
    t_ctr            r_rd;

    t_ctr            mem [TABLE_ENTRIES];

    logic            we;
    logic [IDXW-1:0] waddr;
    t_ctr            wdata;

    // Select clearing write or counter write-back
    always_comb begin
        we    = (r_state == ST_CLEAR) || (r_state == ST_UPDATE);
        waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
        wdata = (r_state == ST_CLEAR) ? CTR_RESET : ctr_next(r_rd, r_tk);
    end

    // Counter memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[i_index];
    end

    // Sequence clearing, lookup and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_lookup) begin
                        r_idx   <= i_index;
                        r_tk    <= i_taken;
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_valid <= 1'b1;
                    r_miss  <= ctr_miss(r_rd, r_tk);
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_status.clearing  = (r_state == ST_CLEAR);
    assign o_status.writeback = (r_state == ST_UPDATE);
    assign o_valid            = r_valid;
    assign o_mispredicted     = r_miss;

endmodule

// ===== rtl/two_bit_counter_branch_predictor_core.sv =====
// ----------------------------------------------------------------------------
// two_bit_counter_branch_predictor_core
// Gshare-style predictor update: one resolved branch per command, one
// mispredict flag per branch.
// ----------------------------------------------------------------------------
// Path: index register, then counter read, then write-back with the strobe;
//   other table sizes add the chunk fold, quotient and remainder registers.
// Occupancy: one branch in flight at a time; busy stays high from acceptance
//   until the counter memory's read-then-write-back is under way.
// Reset: synchronous; clears history and the history length, then sweeps the
//   whole counter memory to weakly not taken with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module two_bit_counter_branch_predictor_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tbcbp_pkg::ADDR_W-1:0]        i_branch_address,
    input  logic                                i_taken,
    output logic                                o_result_valid,
    output logic                                o_mispredicted,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tbcbp_pkg::APB_AW-1:0]        paddr,
    input  logic [tbcbp_pkg::APB_DW-1:0]        pwdata,
    output logic [tbcbp_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);
    import tbcbp_pkg::*;

    localparam int IDXW = $clog2(TABLE_ENTRIES);

    logic             accept;
    logic             r_inflight;
    logic             r_taken;
    logic [CFG_W-1:0] r_history_bits;
    logic             idx_done;
    logic [IDXW-1:0]  idx;
    t_tbl_status      tbl_status;
    t_reg_idx         reg_sel;

    assign accept  = start && !busy;
    assign busy    = r_inflight || tbl_status.clearing;
    assign reg_sel = paddr[APB_AW-1:APB_AW-1];
    assign pready  = 1'b1;

    // Track the beat in flight; release once the write-back is under way
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else if (accept) begin
            r_inflight <= 1'b1;
        end else if (tbl_status.writeback) begin
            r_inflight <= 1'b0;
        end
        if (accept) r_taken <= i_taken;
    end

    // Write the history length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_bits <= '0;
        end else if (psel && penable && pwrite && pready
                     && (reg_sel == REG_HISTORY_BITS)) begin
            r_history_bits <= pwdata[CFG_W-1:0];
        end
    end

    // Read back registers
    always_comb begin
        unique case (reg_sel)
            REG_HISTORY_BITS: prdata = {{(APB_DW-CFG_W){1'b0}}, r_history_bits};
            default:          prdata = '0;
        endcase
    end

    tbcbp_index #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_index (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (accept),
        .i_branch_address (i_branch_address),
        .i_taken          (i_taken),
        .i_history_bits   (r_history_bits),
        .o_done           (idx_done),
        .o_index          (idx)
    );

    tbcbp_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lookup       (idx_done),
        .i_index        (idx),
        .i_taken        (r_taken),
        .o_status       (tbl_status),
        .o_valid        (o_result_valid),
        .o_mispredicted (o_mispredicted)
    );

endmodule

// ===== rtl/tbcbp_checker.sv =====
// ----------------------------------------------------------------------------
// tbcbp_checker
// Port-level checks on command acceptance, busy and the result strobe.
// ----------------------------------------------------------------------------
module tbcbp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);

    // Reset starts the clearing pass, so the block is busy right after
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // An accepted beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted beat");

    // The result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // A result only follows work in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a beat in flight");

endmodule

bind two_bit_counter_branch_predictor_core tbcbp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);
